@@ design/four_way_lru_cache_tag_lookup_unit_macros.svh @@
// Assertion macros shared by the cache tag lookup design.
`ifndef FOUR_WAY_LRU_CACHE_TAG_LOOKUP_UNIT_MACROS_SVH
`define FOUR_WAY_LRU_CACHE_TAG_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define FWLRU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the active-low reset is asserted.
`define FWLRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/fwlru_pkg.sv @@
// Package with shared types and constants of the cache tag lookup unit.
`default_nettype none

package fwlru_pkg;

    localparam int DEF_SET_COUNT = 16384;
    localparam int DEF_TAG_BITS  = 16;
    localparam int WAYS          = 4;
    localparam int WAY_W         = 2;
    localparam int RANK_W        = 2;
    localparam int OFFSET_BITS   = 2;
    localparam int ADDR_W        = 32;
    localparam int CNT_W         = 32;

    typedef logic [WAY_W-1:0]               t_way;
    typedef logic [RANK_W-1:0]              t_rank;
    typedef logic [WAYS-1:0]                t_valid;
    typedef logic [WAYS-1:0][RANK_W-1:0]    t_ranks;

    // Outcome of one lookup and the new recency state of its set.
    typedef struct packed {
        logic   hit;
        t_way   way;
        logic   evict;
        t_valid valid_next;
        t_ranks ranks_next;
    } t_lru_result;

endpackage

`default_nettype wire

@@ design/fwlru_set_ram.sv @@
// Single-port-write, single-port-read set memory with registered read data.
`default_nettype none

module fwlru_set_ram
    import fwlru_pkg::*;
#(
    parameter int DEPTH = DEF_SET_COUNT,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read so a stalled lookup keeps its entry.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/fwlru_lru_update.sv @@
// Tag compare, way choice and true-LRU rank update for one set entry.
`default_nettype none

module fwlru_lru_update
    import fwlru_pkg::*;
#(
    parameter int TAG_BITS = DEF_TAG_BITS
) (
    input  wire logic   [TAG_BITS-1:0]           i_tag,
    input  wire t_valid                          i_valid,
    input  wire logic   [WAYS-1:0][TAG_BITS-1:0] i_tags,
    input  wire t_ranks                          i_ranks,
    output t_lru_result                          o_res,
    output logic        [WAYS-1:0][TAG_BITS-1:0] o_tags_next
);

    logic [WAYS-1:0] match;
    t_way            hit_way;
    t_way            free_way;
    t_way            old_way;
    t_rank           oldest;
    t_rank           old_age;
    t_way            way;
    logic            hit;
    logic            found;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            match[w] = i_valid[w] && (i_tags[w] == i_tag);
        end
        hit      = |match;
        found    = ~&i_valid;
        hit_way  = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = t_way'(w);
            end
            if (!i_valid[w]) begin
                free_way = t_way'(w);
            end
        end
        // Lowest way holding the largest rank; only used when the set is full.
        oldest  = '0;
        old_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (i_ranks[w] > oldest) begin
                oldest  = i_ranks[w];
                old_way = t_way'(w);
            end
        end
    end

    always_comb begin
        o_res.hit        = hit;
        o_res.evict      = 1'b0;
        o_res.valid_next = i_valid;
        o_tags_next      = i_tags;
        if (hit) begin
            way     = hit_way;
            old_age = i_ranks[hit_way];
        end else if (found) begin
            way     = free_way;
            old_age = '1;
            o_res.valid_next[free_way] = 1'b1;
        end else begin
            way         = old_way;
            old_age     = oldest;
            o_res.evict = 1'b1;
        end
        if (!hit) begin
            o_tags_next[way] = i_tag;
        end
        o_res.way = way;
        // Ways younger than the touched one age by one; the touched way becomes newest.
        for (int v = 0; v < WAYS; v++) begin
            if (t_way'(v) == way) begin
                o_res.ranks_next[v] = '0;
            end else if (i_valid[v] && (i_ranks[v] < old_age)) begin
                o_res.ranks_next[v] = i_ranks[v] + t_rank'(1);
            end else begin
                o_res.ranks_next[v] = i_ranks[v];
            end
        end
    end

endmodule

`default_nettype wire

@@ design/four_way_lru_cache_tag_lookup_unit.sv @@
// Flow: an accepted item's set entry is read into the memory's output register, then
// updated and written back to the same memory in the lookup state, where its result is
// registered once the output is free. No new item is taken until that lookup commits.
// Reset: synchronous, active low; it clears the totals and starts a clearing pass
// that zeroes every set entry, during which no item is accepted.
// SET_COUNT must be a power of two, unchecked by the block; the set index is taken straight from address bits.
`default_nettype none

`include "four_way_lru_cache_tag_lookup_unit_macros.svh"

module four_way_lru_cache_tag_lookup_unit
    import fwlru_pkg::*;
#(
    parameter int SET_COUNT = DEF_SET_COUNT,
    parameter int TAG_BITS  = DEF_TAG_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [ADDR_W-1:0] i_access_address,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_is_hit,
    output t_way                   o_way_used,
    output logic                   o_evicted,
    output logic      [CNT_W-1:0]  o_hit_total,
    output logic      [CNT_W-1:0]  o_miss_total
);

    localparam int SET_BITS = $clog2(SET_COUNT);
    localparam int TAGS_W   = WAYS * TAG_BITS;
    localparam int RANKS_W  = WAYS * RANK_W;
    localparam int ENTRY_W  = RANKS_W + TAGS_W + WAYS;

    // One-hot controller: clearing pass, waiting for an item, and the
    // lookup state in which the read entry is updated and written back.
    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [SET_BITS-1:0]  r_clr_addr;
    logic [SET_BITS-1:0]  n_clr_addr;
    logic [SET_BITS-1:0]  r_set;
    logic [TAG_BITS-1:0]  r_tag;
    logic [CNT_W-1:0]     r_hits;
    logic [CNT_W-1:0]     r_misses;
    logic [CNT_W-1:0]     n_hits;
    logic [CNT_W-1:0]     n_misses;
    logic                 r_out_valid;
    logic                 r_is_hit;
    t_way                 r_way_used;
    logic                 r_evicted;

    logic                 in_accept;
    logic                 out_free;
    logic                 commit;
    logic                 mem_we;
    logic [SET_BITS-1:0]  mem_waddr;
    logic [ENTRY_W-1:0]   mem_wdata;
    logic [ENTRY_W-1:0]   mem_rdata;
    logic [SET_BITS-1:0]  in_set;

    t_valid                          rd_valid;
    logic [WAYS-1:0][TAG_BITS-1:0]   rd_tags;
    t_ranks                          rd_ranks;
    t_lru_result                     res;
    logic [WAYS-1:0][TAG_BITS-1:0]   tags_next;

    // An item is taken only when the controller is idle; the output register
    // still lets a finished result wait while the next lookup starts.
    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign in_set     = i_access_address[OFFSET_BITS +: SET_BITS];

    // The lookup finishes once the output register is empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;
    assign commit   = (r_state == S_LOOK) && out_free;

    // Entry layout: ranks on top, then the four tags, valid bits at the bottom.
    assign rd_valid = mem_rdata[WAYS-1:0];
    assign rd_tags  = mem_rdata[WAYS +: TAGS_W];
    assign rd_ranks = mem_rdata[WAYS + TAGS_W +: RANKS_W];

    fwlru_set_ram #(
        .DEPTH (SET_COUNT),
        .WIDTH (ENTRY_W)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (in_accept),
        .i_raddr (in_set),
        .o_rdata (mem_rdata)
    );

    fwlru_lru_update #(
        .TAG_BITS (TAG_BITS)
    ) u_lru_update (
        .i_tag       (r_tag),
        .i_valid     (rd_valid),
        .i_tags      (rd_tags),
        .i_ranks     (rd_ranks),
        .o_res       (res),
        .o_tags_next (tags_next)
    );

    // During the clearing pass whole entries are zeroed, so no valid bit and
    // no stale rank survives reset. Afterwards the memory is written only when
    // a lookup commits. Reads happen only in the idle state, after any earlier
    // write-back, so a read never overlaps a pending write to the same set.
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = commit;
            mem_waddr = r_set;
            mem_wdata = {res.ranks_next, tags_next, res.valid_next};
        end
    end

    // Saturating totals, counted at the commit of each lookup.
    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        if (res.hit) begin
            if (r_hits != '1) begin
                n_hits = r_hits + CNT_W'(1);
            end
        end else begin
            if (r_misses != '1) begin
                n_misses = r_misses + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + SET_BITS'(1);
                if (r_clr_addr == SET_BITS'(SET_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (commit) begin
                r_hits      <= n_hits;
                r_misses    <= n_misses;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Address fields of the item in flight and the result payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_set <= in_set;
            r_tag <= i_access_address[ADDR_W-1 -: TAG_BITS];
        end
        if (commit) begin
            r_is_hit   <= res.hit;
            r_way_used <= res.way;
            r_evicted  <= res.evict;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_hit     = r_is_hit;
    assign o_way_used   = r_way_used;
    assign o_evicted    = r_evicted;
    assign o_hit_total  = r_hits;
    assign o_miss_total = r_misses;

    // A hit must land on a way that was valid in the entry just read.
    `FWLRU_ASSERT_NOW(a_hit_way_valid, i_clk, i_rst_n, commit && res.hit, rd_valid[res.way], "hit on an invalid way")
    // A replacement only happens when every way of the set is valid.
    `FWLRU_ASSERT_NOW(a_evict_full, i_clk, i_rst_n, commit && res.evict, rd_valid == '1, "eviction from a set with a free way")
    // A hit never reports an eviction.
    `FWLRU_ASSERT_NOW(a_hit_no_evict, i_clk, i_rst_n, commit, !(res.hit && res.evict), "hit flagged as eviction")
    // Each committed lookup leaves a result waiting on the output.
    `FWLRU_ASSERT_NEXT(a_commit_out, i_clk, i_rst_n, commit, o_out_valid, "committed lookup lost its result")
    // A miss advances the miss total by one unless it is saturated.
    `FWLRU_ASSERT_NEXT(a_miss_count, i_clk, i_rst_n, commit && !res.hit, (r_misses == $past(r_misses) + CNT_W'(1)) || ($past(r_misses) == '1), "miss total did not advance")

endmodule

`default_nettype wire

@@ test/tb_four_way_lru_cache_tag_lookup_unit.sv @@
// Self-checking testbench of the four-way true-LRU cache tag lookup unit.
module tb_four_way_lru_cache_tag_lookup_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fwlru_pkg::*;

    // Geometry of the default build. The set index sits just above the byte
    // offset, and the tag is the top TAG_W bits of the address.
    localparam int SET_W = $clog2(DEF_SET_COUNT);
    localparam int TAG_W = DEF_TAG_BITS;

    // The least recent way of a full set carries this age.
    localparam bit [RANK_W-1:0] OLDEST_AGE = (RANK_W)'(WAYS - 1);

    // A hold-off of the receiver that is long enough to back the block up
    // into its input side.
    localparam int HOLD_CYCLES = 48;

    // Items in each of the three random phases.
    localparam int PHASE_ITEMS = 310;

    // Size of the pools of tags and sets that the random part mostly draws
    // from, so that hits and evictions happen often.
    localparam int HOT_COUNT = 6;

    // The timeout covers the clearing pass after reset. The rest allows each
    // item a long sender gap, a long receiver stall and the block's own
    // lookup, several times over.
    localparam longint TIMEOUT_NS = 64'd20 * 64'd300_000;

    // One lookup outcome, laid out like the block's result ports.
    typedef struct packed {
        logic               hit;
        t_way               way;
        logic               evict;
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   misses;
    } t_lookup;

    // One row of the directed table. Rows whose outcome can be read off at a
    // glance carry it; the others are left to the predictor.
    typedef struct {
        logic [ADDR_W-1:0]  addr;
        bit                 typed;
        t_lookup            want;
    } t_access_row;

    // What the sender tells the input monitor about the item it offers.
    typedef struct {
        bit                 typed;
        t_lookup            want;
    } t_offered;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [ADDR_W-1:0]  i_access_address;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_is_hit;
    t_way               o_way_used;
    logic               o_evicted;
    logic [CNT_W-1:0]   o_hit_total;
    logic [CNT_W-1:0]   o_miss_total;

    // Predictor state: a private copy of the tag store, the valid bits, the
    // recency ages and the two totals.
    bit [WAYS-1:0]      way_valid [DEF_SET_COUNT];
    bit [TAG_W-1:0]     way_tag   [DEF_SET_COUNT][WAYS];
    bit [RANK_W-1:0]    way_age   [DEF_SET_COUNT][WAYS];
    bit [CNT_W-1:0]     hit_count;
    bit [CNT_W-1:0]     miss_count;

    t_offered           offer_q[$];
    t_lookup            expect_q[$];
    int unsigned        err_count;

    // Idle rates in percent, and the request for a long receiver hold-off.
    // They are set only at a falling edge, so the processes that read them at
    // the rising edge never race with the change.
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;
    bit                 stall_burst_req;

    bit [TAG_W-1:0]     hot_tag [HOT_COUNT];
    bit [SET_W-1:0]     hot_set [HOT_COUNT];

    // Directed accesses. Seven of the first eight fill set 0 way by way, hit
    // a way in the middle of the age order and then evict the least recent
    // way; their outcomes are typed in. The rest revisit evicted tags, hit the
    // oldest way, touch the last set and mix offsets and extreme bit patterns.
    t_access_row access_table [0:21] = '{
        '{32'h0000_0000, 1'b1, '{1'b0, 2'd0, 1'b0, 32'd0, 32'd1}},
        '{32'h0000_0003, 1'b1, '{1'b1, 2'd0, 1'b0, 32'd1, 32'd1}},
        '{32'hFFFF_FFFF, 1'b1, '{1'b0, 2'd0, 1'b0, 32'd1, 32'd2}},
        '{32'h0001_0001, 1'b1, '{1'b0, 2'd1, 1'b0, 32'd1, 32'd3}},
        '{32'h0002_0002, 1'b1, '{1'b0, 2'd2, 1'b0, 32'd1, 32'd4}},
        '{32'h0003_0000, 1'b1, '{1'b0, 2'd3, 1'b0, 32'd1, 32'd5}},
        '{32'h0001_0000, 1'b1, '{1'b1, 2'd1, 1'b0, 32'd2, 32'd5}},
        '{32'h0004_0000, 1'b1, '{1'b0, 2'd0, 1'b1, 32'd2, 32'd6}},
        '{32'h0000_0000, 1'b0, '0},
        '{32'h0003_0000, 1'b0, '0},
        '{32'h0002_0000, 1'b0, '0},
        '{32'hFFFF_0000, 1'b0, '0},
        '{32'h0000_FFFC, 1'b0, '0},
        '{32'hFFFF_FFFC, 1'b0, '0},
        '{32'h8000_0000, 1'b0, '0},
        '{32'h5555_AAAA, 1'b0, '0},
        '{32'hAAAA_5555, 1'b0, '0},
        '{32'h0000_0004, 1'b0, '0},
        '{32'h0000_0005, 1'b0, '0},
        '{32'h0004_0003, 1'b0, '0},
        '{32'h0000_8000, 1'b0, '0},
        '{32'h7FFF_7FFF, 1'b0, '0}
    };

    four_way_lru_cache_tag_lookup_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_access_address (i_access_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_is_hit         (o_is_hit),
        .o_way_used       (o_way_used),
        .o_evicted        (o_evicted),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Make way w the most recent. Valid ways that were younger than w age by
    // one, so the ages of a set stay distinct.
    function automatic void promote_way(int unsigned set_idx, int unsigned w,
                                        bit [RANK_W-1:0] old_age);
        for (int v = 0; v < WAYS; v++) begin
            if (v != w && way_valid[set_idx][v] && way_age[set_idx][v] < old_age) begin
                way_age[set_idx][v] = way_age[set_idx][v] + 1'b1;
            end
        end
        way_age[set_idx][w] = '0;
    endfunction

    // Work out the outcome of one access and update the predictor state.
    function automatic t_lookup predict_lookup(logic [ADDR_W-1:0] addr);
        t_lookup            res;
        bit [TAG_W-1:0]     tag;
        int unsigned        set_idx;
        bit [RANK_W-1:0]    oldest;
        bit                 found;
        res     = '0;
        tag     = addr[ADDR_W-1 -: TAG_W];
        set_idx = addr[OFFSET_BITS +: SET_W];
        found   = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (!found && way_valid[set_idx][w] && way_tag[set_idx][w] == tag) begin
                found   = 1'b1;
                res.hit = 1'b1;
                res.way = t_way'(w);
            end
        end
        if (res.hit) begin
            promote_way(set_idx, res.way, way_age[set_idx][res.way]);
            if (hit_count != '1) begin
                hit_count = hit_count + 1'b1;
            end
        end else begin
            // A miss fills the lowest invalid way first.
            for (int w = 0; w < WAYS; w++) begin
                if (!found && !way_valid[set_idx][w]) begin
                    found   = 1'b1;
                    res.way = t_way'(w);
                end
            end
            if (found) begin
                way_valid[set_idx][res.way] = 1'b1;
                promote_way(set_idx, res.way, OLDEST_AGE);
            end else begin
                // Full set: replace the oldest way, the lowest one on a tie.
                oldest  = '0;
                res.way = '0;
                for (int w = 0; w < WAYS; w++) begin
                    if (way_age[set_idx][w] > oldest) begin
                        oldest  = way_age[set_idx][w];
                        res.way = t_way'(w);
                    end
                end
                res.evict = 1'b1;
                promote_way(set_idx, res.way, oldest);
            end
            way_tag[set_idx][res.way] = tag;
            if (miss_count != '1) begin
                miss_count = miss_count + 1'b1;
            end
        end
        res.hits   = hit_count;
        res.misses = miss_count;
        return res;
    endfunction

    // Most random accesses land on a few sets with a few tags, more tags than
    // ways, so that hits, fills and evictions all come up often. The rest are
    // fully random addresses, which also toggle every address bit.
    function automatic logic [ADDR_W-1:0] random_address();
        logic [ADDR_W-1:0] addr;
        addr = $urandom;
        if ($urandom_range(99) < 75) begin
            addr[ADDR_W-1 -: TAG_W]      = hot_tag[$urandom_range(HOT_COUNT - 1)];
            addr[OFFSET_BITS +: SET_W]   = hot_set[$urandom_range(HOT_COUNT - 1)];
        end
        return addr;
    endfunction

    // Offer one item and return at the rising edge where it is accepted. The
    // valid line only drops when the sender idles, so an item that follows
    // straight on keeps it high without a second assignment in the same step.
    task automatic offer_access(input logic [ADDR_W-1:0] addr, input bit typed,
                                input t_lookup want);
        t_offered ofr;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_access_address <= addr;
        ofr.typed = typed;
        ofr.want  = want;
        offer_q.insert(offer_q.size(), ofr);
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every expected result has come out. The new
    // idle rates, and a receiver hold-off if asked, take effect from there.
    task automatic drain_results(input int unsigned next_send_pct,
                                 input int unsigned next_recv_pct, input bit hold_off);
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (expect_q.size() != 0);
        send_idle_pct   = next_send_pct;
        recv_idle_pct   = next_recv_pct;
        stall_burst_req = hold_off;
        @(posedge i_clk);
    endtask

    task automatic check_result(input t_lookup want);
        if (o_is_hit !== want.hit) begin
            err_count++;
            $error("is_hit: expected %0d, got %0d", want.hit, o_is_hit);
        end
        if (o_way_used !== want.way) begin
            err_count++;
            $error("way_used: expected %0d, got %0d", want.way, o_way_used);
        end
        if (o_evicted !== want.evict) begin
            err_count++;
            $error("evicted: expected %0d, got %0d", want.evict, o_evicted);
        end
        if (o_hit_total !== want.hits) begin
            err_count++;
            $error("hit_total: expected %0d, got %0d", want.hits, o_hit_total);
        end
        if (o_miss_total !== want.misses) begin
            err_count++;
            $error("miss_total: expected %0d, got %0d", want.misses, o_miss_total);
        end
    endtask

    // Both handshakes are sampled at the rising edge, before that edge's
    // updates land. An accepted item is run through the predictor at once;
    // typed directed rows replace the prediction with their own outcome but
    // still advance the predictor state.
    always @(posedge i_clk) begin
        t_offered   rec;
        t_lookup    predicted;
        if (i_in_valid && o_in_ready) begin
            rec       = offer_q.pop_front();
            predicted = predict_lookup(i_access_address);
            expect_q.insert(expect_q.size(), rec.typed ? rec.want : predicted);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expect_q.size() == 0) begin
                err_count++;
                $error("result with no access pending: is_hit %0d way_used %0d",
                       o_is_hit, o_way_used);
            end else begin
                check_result(expect_q.pop_front());
            end
        end
    end

    // Receiver: stalls at random at the current rate, or holds off for a
    // long stretch when asked, counting the cycles itself.
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_burst_req) begin
                stall_burst_req = 1'b0;
                hold_left       = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_access_address <= '0;
        err_count        = 0;
        hit_count        = '0;
        miss_count       = '0;
        send_idle_pct    = 14;
        recv_idle_pct    = 51;
        stall_burst_req  = 1'b0;

        // The pools always hold the extreme tags and the first and last sets.
        hot_tag[0] = '0;
        hot_tag[1] = '1;
        hot_set[0] = '0;
        hot_set[1] = '1;
        for (int k = 2; k < HOT_COUNT; k++) begin
            hot_tag[k] = TAG_W'($urandom);
            hot_set[k] = SET_W'($urandom);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block clears its set entries after reset and holds its input
        // off meanwhile; the handshake simply waits that out.
        foreach (access_table[r]) begin
            offer_access(access_table[r].addr, access_table[r].typed,
                         access_table[r].want);
        end

        // Random phases: the sender idles less than the receiver, then the
        // other way round, then neither idles. Each starts from an empty
        // block with a long receiver hold-off while the sender keeps going.
        drain_results(14, 51, 1'b1);
        repeat (PHASE_ITEMS) offer_access(random_address(), 1'b0, '0);
        drain_results(51, 14, 1'b1);
        repeat (PHASE_ITEMS) offer_access(random_address(), 1'b0, '0);
        drain_results(0, 0, 1'b1);
        repeat (PHASE_ITEMS) offer_access(random_address(), 1'b0, '0);
        drain_results(0, 0, 1'b0);

        // Wait on to catch any stray result past the last one.
        repeat (8) @(posedge i_clk);

        if (err_count == 0) begin
            $display("tb_four_way_lru_cache_tag_lookup_unit OK");
        end else begin
            $display("tb_four_way_lru_cache_tag_lookup_unit NOT OK");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_four_way_lru_cache_tag_lookup_unit NOT OK");
        $finish;
    end

endmodule

@@ four_way_lru_cache_tag_lookup_unit.f @@
+incdir+design
design/fwlru_pkg.sv
design/fwlru_set_ram.sv
design/fwlru_lru_update.sv
design/four_way_lru_cache_tag_lookup_unit.sv
test/tb_four_way_lru_cache_tag_lookup_unit.sv
